@@ rtl/spe_pkg.sv @@
package spe_pkg;

    localparam int ORDER_W    = 4;
    localparam int FS_W       = 18;
    localparam int HZ_W       = 17;
    localparam int FREQ_W     = 25;
    localparam int NOTE_W     = 7;
    localparam int FRAC_W     = 8;
    localparam int MIN_ORDER  = 4;
    localparam int NOTE_EDGES = 127;
    localparam int EDGE_W     = 22;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 18;

    // output tdata field positions
    localparam int PV_LSB   = 0;
    localparam int NOTE_LSB = 1;
    localparam int FREQ_LSB = NOTE_LSB + NOTE_W;
    localparam int BIN_LSB  = FREQ_LSB + FREQ_W;

    localparam logic [FREQ_W-1:0] FREQ_LIMIT = {FREQ_W{1'b1}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FFT_ORDER   = 2'd0,
        CFG_SAMPLE_RATE = 2'd1,
        CFG_MIN_FREQ    = 2'd2,
        CFG_MAX_FREQ    = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_MUL,
        S_DIV,
        S_RND,
        S_NOTE,
        S_DONE
    } t_back_state;

    typedef struct packed {
        logic valid;
        logic ready;
    } t_job_hs;

    // lower edge of each midi note above 0, hz in q8
    localparam logic [EDGE_W-1:0] NOTE_EDGE [0:NOTE_EDGES-1] = '{
        22'd2155, 22'd2283, 22'd2419, 22'd2562, 22'd2715, 22'd2876, 22'd3047, 22'd3228,
        22'd3420, 22'd3624, 22'd3839, 22'd4067, 22'd4309, 22'd4565, 22'd4837, 22'd5124,
        22'd5429, 22'd5752, 22'd6094, 22'd6456, 22'd6840, 22'd7247, 22'd7678, 22'd8134,
        22'd8618, 22'd9130, 22'd9673, 22'd10248, 22'd10858, 22'd11503, 22'd12187,
        22'd12912, 22'd13680, 22'd14493, 22'd15355, 22'd16268, 22'd17235, 22'd18260,
        22'd19346, 22'd20496, 22'd21715, 22'd23006, 22'd24374, 22'd25823, 22'd27359,
        22'd28986, 22'd30709, 22'd32535, 22'd34470, 22'd36520, 22'd38691, 22'd40992,
        22'd43429, 22'd46012, 22'd48748, 22'd51646, 22'd54717, 22'd57971, 22'd61418,
        22'd65070, 22'd68939, 22'd73039, 22'd77382, 22'd81983, 22'd86858, 22'd92023,
        22'd97495, 22'd103292, 22'd109434, 22'd115941, 22'd122835, 22'd130139,
        22'd137878, 22'd146077, 22'd154763, 22'd163965, 22'd173715, 22'd184045,
        22'd194989, 22'd206583, 22'd218867, 22'd231882, 22'd245670, 22'd260278,
        22'd275755, 22'd292153, 22'd309525, 22'd327930, 22'd347430, 22'd368089,
        22'd389977, 22'd413166, 22'd437734, 22'd463763, 22'd491340, 22'd520556,
        22'd551510, 22'd584305, 22'd619049, 22'd655860, 22'd694859, 22'd736177,
        22'd779953, 22'd826331, 22'd875467, 22'd927525, 22'd982679, 22'd1041112,
        22'd1103020, 22'd1168609, 22'd1238098, 22'd1311719, 22'd1389718, 22'd1472354,
        22'd1559905, 22'd1652662, 22'd1750934, 22'd1855050, 22'd1965357, 22'd2082223,
        22'd2206039, 22'd2337217, 22'd2476195, 22'd2623437, 22'd2779435, 22'd2944708,
        22'd3119810
    };

endpackage

@@ rtl/spe_front.sv @@
module spe_front #(
    parameter int MAX_FFT_ORDER = 12,
    parameter int MAG_BITS      = 24,
    parameter int OW            = 5,
    parameter int JOB_W         = 3 * 24 + 11 + 1 + 5
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [spe_pkg::ORDER_W-1:0] i_fft_order,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [MAG_BITS-1:0]         i_mag,
    output spe_pkg::t_job_hs            o_push,
    input  logic                        i_full,
    output logic [JOB_W-1:0]            o_job
);
    import spe_pkg::*;

    localparam int CW = MAX_FFT_ORDER - 1;

    logic [CW-1:0]       r_cnt, n_cnt;
    logic [MAG_BITS-1:0] r_best, n_best;
    logic [CW-1:0]       r_bbin, n_bbin;
    logic [MAG_BITS-1:0] r_prev, n_prev;
    logic [MAG_BITS-1:0] r_left, n_left;
    logic [MAG_BITS-1:0] r_right, n_right;
    logic                r_cap, n_cap;

    logic [OW-1:0] eff_order;
    logic [CW:0]   nbins;
    logic [CW-1:0] last_idx;
    logic          accept;
    logic          last;
    logic          interp;

    always_comb begin
        if (OW'(i_fft_order) < OW'(MIN_ORDER)) begin
            eff_order = OW'(MIN_ORDER);
        end else if (OW'(i_fft_order) > OW'(MAX_FFT_ORDER)) begin
            eff_order = OW'(MAX_FFT_ORDER);
        end else begin
            eff_order = OW'(i_fft_order);
        end
    end

    assign nbins    = (CW+1)'(1) << (eff_order - OW'(1));
    assign last_idx = CW'(nbins - (CW+1)'(1));
    assign o_ready  = !i_full;
    assign accept   = i_valid && o_ready;
    assign last     = r_cnt >= last_idx;

    always_comb begin
        n_right = r_cap ? i_mag : r_right;
        n_cap   = 1'b0;
        n_best  = r_best;
        n_bbin  = r_bbin;
        n_left  = r_left;
        if (r_cnt >= CW'(2) && i_mag > r_best) begin
            n_best = i_mag;
            n_bbin = r_cnt;
            n_left = r_prev;
            n_cap  = 1'b1;
        end
        n_prev = i_mag;
        n_cnt  = r_cnt + CW'(1);
    end

    assign interp = (n_bbin > CW'(1)) && (n_bbin < last_idx);

    assign o_push.valid = accept && last;
    assign o_push.ready = 1'b0;
    assign o_job        = {eff_order, interp, n_bbin, n_right, n_best, n_left};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (accept && last)) begin
            r_cnt   <= '0;
            r_best  <= '0;
            r_bbin  <= '0;
            r_prev  <= '0;
            r_left  <= '0;
            r_right <= '0;
            r_cap   <= 1'b0;
        end else if (accept) begin
            r_cnt   <= n_cnt;
            r_best  <= n_best;
            r_bbin  <= n_bbin;
            r_prev  <= n_prev;
            r_left  <= n_left;
            r_right <= n_right;
            r_cap   <= n_cap;
        end
    end

endmodule

@@ rtl/spe_job_fifo.sv @@
module spe_job_fifo #(
    parameter int JOB_W = 93
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  spe_pkg::t_job_hs i_push,
    input  logic [JOB_W-1:0] i_wdata,
    output logic             o_full,
    input  spe_pkg::t_job_hs i_pop,
    output logic             o_empty,
    output logic [JOB_W-1:0] o_rdata
);
    import spe_pkg::*;

    logic [JOB_W-1:0] r_mem [0:1];
    logic             r_wp, r_rp;
    logic [1:0]       r_cnt;
    logic             do_push, do_pop;

    assign o_full  = r_cnt == 2'd2;
    assign o_empty = r_cnt == 2'd0;
    assign o_rdata = r_mem[r_rp];
    assign do_push = i_push.valid && !o_full;
    assign do_pop  = i_pop.ready && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= !r_wp;
            end
            if (do_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(do_push) - 2'(do_pop);
        end
    end

endmodule

@@ rtl/spe_back.sv @@
module spe_back #(
    parameter int MAX_FFT_ORDER = 12,
    parameter int MAG_BITS      = 24,
    parameter int OW            = 5,
    parameter int JOB_W         = 93,
    parameter int OUT_W         = 48
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [spe_pkg::FS_W-1:0] i_fs,
    input  logic [spe_pkg::HZ_W-1:0] i_min_hz,
    input  logic [spe_pkg::HZ_W-1:0] i_max_hz,
    input  logic                     i_empty,
    input  logic [JOB_W-1:0]         i_job,
    output spe_pkg::t_job_hs         o_pop,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [OUT_W-1:0]         o_data
);
    import spe_pkg::*;

    localparam int CW    = MAX_FFT_ORDER - 1;
    localparam int DW    = MAG_BITS + 4;
    localparam int DENW  = MAG_BITS + 3;
    localparam int NSW   = CW + DW + 2;
    localparam int NW    = NSW - 1;
    localparam int PW    = NW + FS_W;
    localparam int DVW   = PW + FRAC_W;
    localparam int QW    = FREQ_W + MAX_FFT_ORDER + 1;
    localparam int CNT_W = $clog2(DVW + 1);

    t_back_state r_state, n_state;

    logic [OW-1:0]       r_order;
    logic                r_interp;
    logic [CW-1:0]       r_bin;
    logic [MAG_BITS-1:0] r_a, r_b, r_c;
    logic [NW-1:0]       r_num;
    logic [DENW-1:0]     r_den;
    logic [FS_W-1:0]     r_mcand;
    logic [PW-1:0]       r_prod;
    logic [DVW-1:0]      r_dvd;
    logic [DENW-1:0]     r_rem;
    logic [QW-1:0]       r_quo;
    logic                r_ovf;
    logic [CNT_W-1:0]    r_cnt;
    logic [FREQ_W-1:0]   r_fq;
    logic [NOTE_W-1:0]   r_note;
    logic [2:0]          r_nbit;
    logic                r_ovalid;
    logic [OUT_W-1:0]    r_odata;

    logic signed [DW-1:0]  s_a, s_b, s_c, s_d;
    logic signed [NSW-1:0] s_num;
    logic [DENW:0]         rem_sh;
    logic                  rem_ge;
    logic [QW:0]           rounded;
    logic [NOTE_W-1:0]     cand;
    logic                  edge_le;
    logic                  pv;
    logic                  out_free;

    assign out_free = !r_ovalid || i_ready;

    // interpolation numerator bin*d + (a-c) with denominator d
    always_comb begin
        s_a   = $signed(DW'(r_a));
        s_b   = $signed(DW'(r_b));
        s_c   = $signed(DW'(r_c));
        s_d   = (s_a - (s_b <<< 1) + s_c) <<< 1;
        s_num = $signed({{(NSW-CW){1'b0}}, r_bin}) * NSW'(s_d) + NSW'(s_a - s_c);
        if (s_d < 0) begin
            s_num = -s_num;
        end
    end

    assign rem_sh = {r_rem, r_dvd[DVW-1]};
    assign rem_ge = rem_sh >= (DENW+1)'(r_den);

    assign rounded = ((QW+1)'(r_quo) + ((QW+1)'(1) << (r_order - OW'(1)))) >> r_order;

    assign cand    = r_note | (NOTE_W'(1) << r_nbit);
    assign edge_le = FREQ_W'(NOTE_EDGE[cand - NOTE_W'(1)]) <= r_fq;

    assign pv = (r_fq > (FREQ_W'(i_min_hz) << FRAC_W)) && (r_fq < (FREQ_W'(i_max_hz) << FRAC_W));

    always_comb begin
        n_state     = r_state;
        o_pop.ready = 1'b0;
        o_pop.valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    o_pop.ready = 1'b1;
                    n_state     = S_PREP;
                end
            end
            S_PREP: begin
                if (r_interp && s_d != 0 && s_num <= 0) begin
                    n_state = S_NOTE;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                if (r_cnt == CNT_W'(1)) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (r_cnt == CNT_W'(1)) begin
                    n_state = S_RND;
                end
            end
            S_RND:  n_state = S_NOTE;
            S_NOTE: begin
                if (r_nbit == 3'd0) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                {r_order, r_interp, r_bin, r_c, r_b, r_a} <= i_job;
            end
            S_PREP: begin
                r_mcand <= i_fs;
                r_prod  <= '0;
                r_cnt   <= CNT_W'(FS_W);
                r_note  <= '0;
                r_nbit  <= 3'(NOTE_W - 1);
                r_fq    <= '0;
                if (r_interp && s_d != 0) begin
                    r_num <= NW'(s_num);
                    r_den <= DENW'(s_d < 0 ? -s_d : s_d);
                end else begin
                    r_num <= NW'(r_bin);
                    r_den <= DENW'(1);
                end
            end
            S_MUL: begin
                r_prod  <= (r_prod << 1) + (r_mcand[FS_W-1] ? PW'(r_num) : PW'(0));
                r_mcand <= r_mcand << 1;
                r_cnt   <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_dvd <= {(r_prod << 1) + (r_mcand[FS_W-1] ? PW'(r_num) : PW'(0)),
                              FRAC_W'(0)};
                    r_rem <= '0;
                    r_quo <= '0;
                    r_ovf <= 1'b0;
                    r_cnt <= CNT_W'(DVW);
                end
            end
            S_DIV: begin
                r_rem <= rem_ge ? DENW'(rem_sh - (DENW+1)'(r_den)) : DENW'(rem_sh);
                r_quo <= {r_quo[QW-2:0], rem_ge};
                r_ovf <= r_ovf | r_quo[QW-1];
                r_dvd <= r_dvd << 1;
                r_cnt <= r_cnt - CNT_W'(1);
            end
            S_RND: begin
                if (r_ovf || rounded >= (QW+1)'(FREQ_LIMIT)) begin
                    r_fq <= FREQ_LIMIT;
                end else begin
                    r_fq <= FREQ_W'(rounded);
                end
            end
            S_NOTE: begin
                // binary search for the count of edges at or below the frequency
                if (edge_le) begin
                    r_note <= cand;
                end
                r_nbit <= r_nbit - 3'd1;
            end
            S_DONE: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            r_odata <= OUT_W'({r_bin, r_fq, pv ? r_note : NOTE_W'(0), pv});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == S_DONE && out_free) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    assign o_valid = r_ovalid;
    assign o_data  = r_odata;

endmodule

@@ rtl/spectral_peak_pitch_estimator_core.sv @@
// spectral peak pitch estimator
// s_axis: one spectrum magnitude per request, bins 0 .. 2^(fft_order-1)-1 of a
//   frame in order; tdata holds the magnitude. one bin per cycle is taken
//   while the job queue between front and back has room.
// m_axis: one result per frame; tdata holds pitch_valid, midi_note,
//   frequency_q8 and peak_bin from the lowest bit up.
// cfg: register index and data, always ready; write only while idle.
// the front tracks the peak and its neighbours at the bin rate and queues a
//   job at the last bin of each frame; the back works one job at a time:
//   a pop, a setup step, a shift-add multiply by the sample rate, a
//   restoring divide one quotient bit a cycle, a rounding step, a 7-step
//   note search and an output step; a job whose interpolated bin is not
//   positive skips the multiply, divide and rounding and gives frequency
//   zero. the back pops no new job until its last result is in the output
//   register. two frames can be queued; when the back falls behind, the
//   input tready drops until a job slot frees.
// a finished result waits in the output register while the receiver stalls;
//   the back holds its next result until that register is taken.
// reset (synchronous, active low) clears frame state, the queue, the output
//   valid and restores the register defaults.
module spectral_peak_pitch_estimator_core #(
    parameter int MAX_FFT_ORDER = 12,
    parameter int MAG_BITS      = 24
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // magnitude
    input  logic [((MAG_BITS+7)/8)*8-1:0]  i_s_axis_tdata,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // pitch_valid, midi_note, frequency_q8, peak_bin
    output logic [((MAX_FFT_ORDER+39)/8)*8-1:0] o_m_axis_tdata,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [spe_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [spe_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import spe_pkg::*;

    localparam int CW    = MAX_FFT_ORDER - 1;
    localparam int OW    = $clog2(MAX_FFT_ORDER + 1);
    localparam int JOB_W = 3 * MAG_BITS + CW + 1 + OW;
    localparam int OUT_W = ((MAX_FFT_ORDER + 39) / 8) * 8;

    logic [ORDER_W-1:0] r_order;
    logic [FS_W-1:0]    r_fs;
    logic [HZ_W-1:0]    r_min_hz;
    logic [HZ_W-1:0]    r_max_hz;

    t_job_hs          push, pop;
    logic             full, empty;
    logic [JOB_W-1:0] job_in, job_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order  <= ORDER_W'(11);
            r_fs     <= FS_W'(44100);
            r_min_hz <= HZ_W'(50);
            r_max_hz <= HZ_W'(2000);
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_FFT_ORDER:   r_order  <= i_cfg_data[ORDER_W-1:0];
                CFG_SAMPLE_RATE: r_fs     <= i_cfg_data[FS_W-1:0];
                CFG_MIN_FREQ:    r_min_hz <= i_cfg_data[HZ_W-1:0];
                CFG_MAX_FREQ:    r_max_hz <= i_cfg_data[HZ_W-1:0];
                default: ;
            endcase
        end
    end

    spe_front #(
        .MAX_FFT_ORDER(MAX_FFT_ORDER), .MAG_BITS(MAG_BITS), .OW(OW), .JOB_W(JOB_W)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fft_order (r_order),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_mag       (i_s_axis_tdata[MAG_BITS-1:0]),
        .o_push      (push),
        .i_full      (full),
        .o_job       (job_in)
    );

    spe_job_fifo #(.JOB_W(JOB_W)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (job_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_rdata (job_out)
    );

    spe_back #(
        .MAX_FFT_ORDER(MAX_FFT_ORDER), .MAG_BITS(MAG_BITS), .OW(OW),
        .JOB_W(JOB_W), .OUT_W(OUT_W)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fs     (r_fs),
        .i_min_hz (r_min_hz),
        .i_max_hz (r_max_hz),
        .i_empty  (empty),
        .i_job    (job_out),
        .o_pop    (pop),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_data   (o_m_axis_tdata)
    );

endmodule

@@ rtl/spe_checker.sv @@
module spe_checker #(
    parameter int OUT_W = 48
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_m_axis_tvalid,
    input logic             i_m_axis_tready,
    input logic [OUT_W-1:0] o_m_axis_tdata
);
    import spe_pkg::*;

    logic             pv;
    logic [NOTE_W-1:0] note;
    logic [FREQ_W-1:0] fq;

    assign pv   = o_m_axis_tdata[PV_LSB];
    assign note = o_m_axis_tdata[NOTE_LSB +: NOTE_W];
    assign fq   = o_m_axis_tdata[FREQ_LSB +: FREQ_W];

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result changed while stalled");

    a_note_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !pv |-> note == '0)
        else $error("note set on invalid pitch");

    a_freq_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && pv |-> fq != '0)
        else $error("valid pitch at zero frequency");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind spectral_peak_pitch_estimator_core spe_checker #(.OUT_W(OUT_W)) u_spe_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
